@@ design/mft_pkg.sv @@
// Package for the message flow table: beat payload structs, command and
// status codes, and the stored entry layout. No dependencies.
package mft_pkg;

    // Command codes carried in the input beat
    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2
    } mft_cmd_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_CLOSED    = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_BAD_QUEUE = 3'd4,
        ST_FULL      = 3'd5
    } mft_status_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_CHANNEL_OPEN = 2'd0;
    localparam logic [1:0] CFG_QUEUE_MASK   = 2'd1;

    localparam int KEY_W   = 16;
    localparam int LIMIT_W = 16;
    localparam int QUEUE_W = 3;
    localparam int SLOT_W  = 5;
    localparam int QIDX_W  = 16;
    localparam int MASK_W  = 8;

    typedef struct packed {
        logic [1:0]         command;
        logic [KEY_W-1:0]   msg_id;
        logic [LIMIT_W-1:0] msg_limit;
        logic [QIDX_W-1:0]  queue_index;
    } mft_in_t;

    typedef struct packed {
        logic               ok;
        logic [2:0]         status;
        logic [SLOT_W-1:0]  slot;
        logic [LIMIT_W-1:0] flow_limit;
        logic [QUEUE_W-1:0] flow_queue;
    } mft_out_t;

    // One stored flow
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [LIMIT_W-1:0] limit;
        logic [QUEUE_W-1:0] queue;
    } mft_entry_t;

endpackage

@@ design/mft_store.sv @@
// Flow table storage: one synchronous memory of entries plus an occupied
// bit per slot (cleared by reset). Depends on mft_pkg.
module mft_store
    import mft_pkg::*;
#(
    parameter int NUM_FLOWS = 32,
    parameter int IDX_W     = 5
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output mft_entry_t       rd_entry,
    output logic             rd_occupied,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  mft_entry_t       wr_entry,
    input  logic             wr_occupy
);

    mft_entry_t           mem [NUM_FLOWS];
    logic [NUM_FLOWS-1:0] occ_reg;
    mft_entry_t           rd_entry_reg;
    logic                 rd_occ_reg;

    // Entry memory: write on add, registered read
    always_ff @(posedge aclk) begin
        if (wr_en && wr_occupy) begin
            mem[wr_addr] <= wr_entry;
        end
        if (rd_en) begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    // Occupied bits; a remove clears only the slot's bit and leaves its old entry in memory
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg    <= '0;
            rd_occ_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                occ_reg[wr_addr] <= wr_occupy;
            end
            if (rd_en) begin
                rd_occ_reg <= occ_reg[rd_addr];
            end
        end
    end

    assign rd_entry    = rd_entry_reg;
    assign rd_occupied = rd_occ_reg;

endmodule

@@ design/message_flow_table.sv @@
// Message flow table: add, remove and query flows keyed by message ID.
// Each command scans the table, reading every slot in turn from the table memory,
// then registers its result in a finish step; a closed channel skips the scan.
// A new command is taken only in the idle state, once the last one has finished; a result
// still unaccepted holds the next command at its finish step.
// Synchronous active-low reset empties the table and clears both configuration registers.
module message_flow_table
    import mft_pkg::*;
#(
    parameter int NUM_FLOWS  = 32,
    parameter int NUM_QUEUES = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  mft_in_t    s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output mft_out_t   m_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    localparam int IDX_W = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
    localparam int CNT_W = IDX_W + 1;
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(NUM_FLOWS);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t              st_reg, st_next;
    logic                open_reg;
    logic [MASK_W-1:0]   qmask_reg;
    mft_in_t             cmd_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                chk_reg;
    logic [IDX_W-1:0]    chk_idx_reg;
    logic                hit_reg;
    logic [IDX_W-1:0]    hit_idx_reg;
    logic [LIMIT_W-1:0]  hit_lim_reg;
    logic [QUEUE_W-1:0]  hit_q_reg;
    logic                free_reg;
    logic [IDX_W-1:0]    free_idx_reg;
    logic                m_valid_reg;
    mft_out_t            m_data_reg;

    logic                rd_en;
    mft_entry_t          rd_entry;
    logic                rd_occ;
    logic                wr_en;
    logic                wr_occupy;
    logic [IDX_W-1:0]    wr_addr;
    mft_entry_t          wr_entry;
    logic                slot_match;
    logic                slot_empty;
    logic                fin_go;
    logic                queue_ok;
    mft_out_t            res;
    logic [IDX_W-1:0]    res_idx;
    logic [IDX_W+SLOT_W-1:0] res_idx_ext;

    mft_store #(
        .NUM_FLOWS (NUM_FLOWS),
        .IDX_W     (IDX_W)
    ) u_store (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .rd_en       (rd_en),
        .rd_addr     (cnt_reg[IDX_W-1:0]),
        .rd_entry    (rd_entry),
        .rd_occupied (rd_occ),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_entry    (wr_entry),
        .wr_occupy   (wr_occupy)
    );

    // Configuration registers, always ready
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg  <= 1'b0;
            qmask_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_CHANNEL_OPEN: open_reg  <= cfg_data[0];
                CFG_QUEUE_MASK:   qmask_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Scan compare on the slot read last cycle; key 0 matches an empty slot
    assign rd_en      = (st_reg == S_SCAN) && (cnt_reg < CNT_END);
    assign slot_empty = chk_reg && !rd_occ;
    assign slot_match = chk_reg && ((cmd_reg.msg_id == '0) ? !rd_occ
                                   : (rd_occ && rd_entry.key == cmd_reg.msg_id));

    assign queue_ok = (cmd_reg.queue_index < QIDX_W'(NUM_QUEUES))
                      && qmask_reg[cmd_reg.queue_index[2:0]];

    // Result of the finished scan, or of a command on a closed channel
    always_comb begin
        res       = '0;
        res_idx   = '0;
        wr_en     = 1'b0;
        wr_occupy = 1'b0;
        res.status = ST_OK;
        if (!open_reg) begin
            res.status = ST_CLOSED;
        end else begin
            case (cmd_reg.command)
                CMD_ADD: begin
                    if (hit_reg) begin
                        res.status = ST_DUPLICATE;
                    end else if (!free_reg) begin
                        res.status = ST_FULL;
                    end else if (!queue_ok) begin
                        res.status = ST_BAD_QUEUE;
                    end else begin
                        res.ok    = 1'b1;
                        res_idx   = free_idx_reg;
                        wr_en     = fin_go;
                        wr_occupy = 1'b1;
                    end
                end
                CMD_REMOVE: begin
                    if (!hit_reg) begin
                        res.status = ST_NOT_FOUND;
                    end else begin
                        res.ok  = 1'b1;
                        res_idx = hit_idx_reg;
                        wr_en   = fin_go;
                    end
                end
                default: begin
                    if (!hit_reg) begin
                        res.status = ST_NOT_FOUND;
                    end else begin
                        res.ok         = 1'b1;
                        res_idx        = hit_idx_reg;
                        res.flow_limit = hit_lim_reg;
                        res.flow_queue = hit_q_reg;
                    end
                end
            endcase
        end
        res_idx_ext = {{SLOT_W{1'b0}}, res_idx};
        res.slot    = res_idx_ext[SLOT_W-1:0];
    end

    assign wr_addr        = res_idx;
    assign wr_entry.key   = cmd_reg.msg_id;
    assign wr_entry.limit = cmd_reg.msg_limit;
    assign wr_entry.queue = cmd_reg.queue_index[QUEUE_W-1:0];

    assign fin_go = (st_reg == S_FINISH) && (!m_valid_reg || m_ready);

    // Sequencer
    always_comb begin
        st_next = st_reg;
        case (st_reg)
            S_IDLE: begin
                if (s_valid) begin
                    st_next = open_reg ? S_SCAN : S_FINISH;
                end
            end
            S_SCAN: begin
                if (cnt_reg == CNT_END && !chk_reg) begin
                    st_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (fin_go) begin
                    st_next = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= S_IDLE;
            chk_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg  <= st_next;
            chk_reg <= rd_en;
            if (fin_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Command capture, scan counter and first-hit / first-free tracking
    always_ff @(posedge aclk) begin
        chk_idx_reg <= cnt_reg[IDX_W-1:0];
        if (st_reg == S_IDLE && s_valid) begin
            cmd_reg  <= s_data;
            cnt_reg  <= '0;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end else begin
            if (rd_en) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (slot_match && !hit_reg) begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= chk_idx_reg;
                hit_lim_reg <= rd_occ ? rd_entry.limit : '0;
                hit_q_reg   <= rd_occ ? rd_entry.queue : '0;
            end
            if (slot_empty && !free_reg) begin
                free_reg     <= 1'b1;
                free_idx_reg <= chk_idx_reg;
            end
        end
        if (fin_go) begin
            m_data_reg <= res;
        end
    end

    assign s_ready = (st_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A successful add always has an empty slot and no existing match
    a_add_has_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && wr_occupy) |-> (free_reg && !hit_reg))
        else $error("add written without a free slot");

    // Slot compares only happen during the scan
    a_chk_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        chk_reg |-> (st_reg == S_SCAN))
        else $error("slot compare outside scan");

    // A new result only appears after the finish step
    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(st_reg == S_FINISH))
        else $error("result raised outside finish");

    // A failed command leaves the table untouched
    a_no_write_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (res.ok && open_reg && st_reg == S_FINISH))
        else $error("table written by a failed command");

endmodule
